// ----- sv/nearest_palette_color_classifier_macros.svh -----
// Assertion macros for the nearest palette color classifier.
// Used by the top level; no other dependencies.
`ifndef NEAREST_PALETTE_COLOR_CLASSIFIER_MACROS_SVH
`define NEAREST_PALETTE_COLOR_CLASSIFIER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define NPCC_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");
// Next-cycle implication.
`define NPCC_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");
`else
`define NPCC_ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define NPCC_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

// ----- sv/npcc_pkg.sv -----
// Shared types, constants and functions of the nearest palette color classifier.
// No dependencies; used by every module of the block.
`default_nettype none

package npcc_pkg;

  // Palette geometry.
  localparam int PALETTE_DEPTH = 256;
  localparam int ADDR_W        = $clog2(PALETTE_DEPTH);
  localparam int COUNT_W       = $clog2(PALETTE_DEPTH + 1);
  localparam int DIST_W        = 18;
  localparam int THR_W         = 18;
  localparam int CFG_DATA_W    = 18;
  localparam int CFG_INDEX_W   = 2;

  // Command queue depth between front and back.
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  // Number of fixed forest colors checked in fast mode.
  localparam int FOREST_COUNT  = 3;

  // Input op codes.
  localparam logic OP_CLASSIFY = 1'b0;
  localparam logic OP_LOAD     = 1'b1;

  // Mode register codes.
  localparam logic MODE_FULL   = 1'b0;
  localparam logic MODE_FAST   = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_MODE      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIZE      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 2'd2;

  // Reset values of the configuration registers.
  localparam logic               MODE_RESET      = MODE_FAST;
  localparam logic [COUNT_W-1:0] SIZE_RESET      = 9'd1;
  localparam logic [THR_W-1:0]   THRESHOLD_RESET = 18'd65;

  // Fast mode result ids.
  localparam logic [7:0] FAST_HIT_ID  = 8'd9;
  localparam logic [7:0] FAST_MISS_ID = 8'd0;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_FULL,
    CMD_FAST
  } cmd_kind_t;

  // One queued transaction from the front to the back.
  typedef struct packed {
    cmd_kind_t          kind;
    pixel_t             pixel;
    logic [ADDR_W-1:0]  slot;
    logic [7:0]         entry_id;
    logic [COUNT_W-1:0] count;
  } cmd_t;

  // Status of the command queue.
  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_WAIT
  } back_state_t;

  // Fixed forest colors in byte units.
  function automatic pixel_t forest_color(input logic [1:0] k);
    pixel_t c;
    case (k)
      2'd0:    c = '{alpha: 8'd255, blue: 8'd99,  green: 8'd170, red: 8'd104};
      2'd1:    c = '{alpha: 8'd255, blue: 8'd48,  green: 8'd99,  red: 8'd28};
      2'd2:    c = '{alpha: 8'd255, blue: 8'd142, green: 8'd201, red: 8'd181};
      default: c = '{alpha: 8'd255, blue: 8'd142, green: 8'd201, red: 8'd181};
    endcase
    return c;
  endfunction

  // Squared difference of two bytes.
  function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return 16'(d) * 16'(d);
  endfunction

  // Squared RGBA distance; the largest value is 260100 and fits 18 bits.
  function automatic logic [DIST_W-1:0] sq_dist(input pixel_t a, input pixel_t b);
    return DIST_W'(sq_diff(a.red, b.red)) + DIST_W'(sq_diff(a.green, b.green))
         + DIST_W'(sq_diff(a.blue, b.blue)) + DIST_W'(sq_diff(a.alpha, b.alpha));
  endfunction

endpackage

`default_nettype wire

// ----- sv/npcc_front.sv -----
// Front end: configuration registers, transaction acceptance and decoding.
// Depends on npcc_pkg; feeds npcc_queue.
`default_nettype none

module npcc_front (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  input  wire logic                                  op,
  input  wire logic [7:0]                            red,
  input  wire logic [7:0]                            green,
  input  wire logic [7:0]                            blue,
  input  wire logic [7:0]                            alpha,
  input  wire logic [7:0]                            slot,
  input  wire logic [7:0]                            entry_id,
  input  wire logic                                  cfg_write,
  input  wire logic [npcc_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [npcc_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire npcc_pkg::queue_status_t               q_status,
  output logic                                       push,
  output npcc_pkg::cmd_t                             push_cmd,
  output logic [npcc_pkg::THR_W-1:0]                 threshold
);

  logic                         mode;
  logic [npcc_pkg::COUNT_W-1:0] palette_size;
  logic [npcc_pkg::COUNT_W-1:0] eff_count;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= npcc_pkg::MODE_RESET;
      palette_size <= npcc_pkg::SIZE_RESET;
      threshold    <= npcc_pkg::THRESHOLD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        npcc_pkg::CFG_MODE:      mode         <= cfg_data[0];
        npcc_pkg::CFG_SIZE:      palette_size <= cfg_data[npcc_pkg::COUNT_W-1:0];
        npcc_pkg::CFG_THRESHOLD: threshold    <= cfg_data[npcc_pkg::THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // A size of zero searches slot 0 alone; sizes past the depth saturate at the depth.
  always_comb begin
    if (palette_size == '0) begin
      eff_count = npcc_pkg::COUNT_W'(1);
    end else if (palette_size > npcc_pkg::COUNT_W'(npcc_pkg::PALETTE_DEPTH)) begin
      eff_count = npcc_pkg::COUNT_W'(npcc_pkg::PALETTE_DEPTH);
    end else begin
      eff_count = palette_size;
    end
  end

  // Accept a transaction whenever the queue has room, and decode its kind.
  always_comb begin
    push                 = start && !q_status.full;
    push_cmd.pixel       = '{alpha: alpha, blue: blue, green: green, red: red};
    push_cmd.slot        = slot[npcc_pkg::ADDR_W-1:0];
    push_cmd.entry_id    = entry_id;
    push_cmd.count       = eff_count;
    if (op == npcc_pkg::OP_LOAD) begin
      push_cmd.kind = npcc_pkg::CMD_LOAD;
    end else if (mode == npcc_pkg::MODE_FAST) begin
      push_cmd.kind = npcc_pkg::CMD_FAST;
    end else begin
      push_cmd.kind = npcc_pkg::CMD_FULL;
    end
  end

endmodule

`default_nettype wire

// ----- sv/npcc_queue.sv -----
// Short command queue between the front end and the back end.
// Depends on npcc_pkg.
`default_nettype none

module npcc_queue (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  input  wire npcc_pkg::cmd_t           push_cmd,
  input  wire logic                     pop,
  output npcc_pkg::cmd_t                head,
  output npcc_pkg::queue_status_t       status
);

  npcc_pkg::cmd_t              entries [npcc_pkg::QUEUE_DEPTH];
  logic [npcc_pkg::QPTR_W-1:0] wr_ptr;
  logic [npcc_pkg::QPTR_W-1:0] rd_ptr;
  logic [npcc_pkg::QCNT_W-1:0] fill;

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == npcc_pkg::QPTR_W'(npcc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == npcc_pkg::QPTR_W'(npcc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  assign head         = entries[rd_ptr];
  assign status.empty = (fill == '0);
  assign status.full  = (fill == npcc_pkg::QCNT_W'(npcc_pkg::QUEUE_DEPTH));

endmodule

`default_nettype wire

// ----- sv/npcc_back.sv -----
// Back end: palette memory, shared distance unit and search sequencer.
// Depends on npcc_pkg; takes commands from npcc_queue.
`default_nettype none

module npcc_back (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire npcc_pkg::cmd_t           head,
  input  wire npcc_pkg::queue_status_t  q_status,
  input  wire logic [npcc_pkg::THR_W-1:0] threshold,
  output logic                          pop,
  output logic                          done,
  output logic [7:0]                    attribute_id
);

  npcc_pkg::back_state_t state;
  npcc_pkg::back_state_t state_next;

  // Palette memory: attribute id above the packed color.
  logic [39:0] palette [npcc_pkg::PALETTE_DEPTH];

  logic                          issue;
  logic                          last_issue;
  logic                          start_pixel;
  npcc_pkg::pixel_t              px;
  logic                          fast;
  logic [npcc_pkg::COUNT_W-1:0]  count;
  logic [npcc_pkg::COUNT_W-1:0]  idx;
  logic [39:0]                   rd_entry;
  npcc_pkg::pixel_t              forest;
  npcc_pkg::pixel_t              operand;
  logic                          v1;
  logic                          last1;
  logic                          v2;
  logic                          last2;
  logic [npcc_pkg::DIST_W-1:0]   pair_dist;
  logic [7:0]                    attr2;
  logic                          first;
  logic [npcc_pkg::DIST_W-1:0]   best_dist;
  logic [7:0]                    best_attr;
  logic                          hit;
  logic                          take;
  logic                          match;
  logic [7:0]                    result;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= npcc_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign last_issue = (idx == count - 1'b1);

  // Next state and sequencer controls.
  always_comb begin
    state_next  = state;
    pop         = 1'b0;
    issue       = 1'b0;
    start_pixel = 1'b0;
    unique case (state)
      npcc_pkg::B_IDLE: begin
        if (!q_status.empty) begin
          pop = 1'b1;
          if (head.kind != npcc_pkg::CMD_LOAD) begin
            start_pixel = 1'b1;
            state_next  = npcc_pkg::B_RUN;
          end
        end
      end
      npcc_pkg::B_RUN: begin
        issue = 1'b1;
        if (last_issue) begin
          state_next = npcc_pkg::B_WAIT;
        end
      end
      npcc_pkg::B_WAIT: begin
        if (v2 && last2) begin
          state_next = npcc_pkg::B_IDLE;
        end
      end
      default: state_next = npcc_pkg::B_IDLE;
    endcase
  end

  // Palette load.
  always_ff @(posedge clk) begin
    if (pop && head.kind == npcc_pkg::CMD_LOAD) begin
      palette[head.slot] <= {head.entry_id, head.pixel};
    end
  end

  // Registered palette read and forest color at the issue index.
  always_ff @(posedge clk) begin
    rd_entry <= palette[idx[npcc_pkg::ADDR_W-1:0]];
    forest   <= npcc_pkg::forest_color(idx[1:0]);
  end

  // Latch the pixel and the slot count, then step the index.
  always_ff @(posedge clk) begin
    if (start_pixel) begin
      px    <= head.pixel;
      fast  <= (head.kind == npcc_pkg::CMD_FAST);
      count <= (head.kind == npcc_pkg::CMD_FAST) ?
               npcc_pkg::COUNT_W'(npcc_pkg::FOREST_COUNT) : head.count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (start_pixel) begin
      idx <= '0;
    end else if (issue) begin
      idx <= idx + 1'b1;
    end
  end

  // Pipeline valid and last flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      last1 <= 1'b0;
      v2    <= 1'b0;
      last2 <= 1'b0;
    end else begin
      v1    <= issue;
      last1 <= issue && last_issue;
      v2    <= v1;
      last2 <= last1;
    end
  end

  // Distance stage.
  assign operand = fast ? forest : npcc_pkg::pixel_t'(rd_entry[31:0]);

  always_ff @(posedge clk) begin
    pair_dist <= npcc_pkg::sq_dist(px, operand);
    attr2     <= rd_entry[39:32];
  end

  // Compare stage: the first slot always wins, later ones only when strictly closer.
  assign take   = first || (pair_dist < best_dist);
  assign match  = (pair_dist <= threshold);
  assign result = fast ? ((hit || match) ? npcc_pkg::FAST_HIT_ID : npcc_pkg::FAST_MISS_ID)
                       : (take ? attr2 : best_attr);

  always_ff @(posedge clk) begin
    if (rst) begin
      first <= 1'b1;
      hit   <= 1'b0;
    end else if (start_pixel) begin
      first <= 1'b1;
      hit   <= 1'b0;
    end else if (v2) begin
      first <= 1'b0;
      hit   <= hit || match;
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && take) begin
      best_dist <= pair_dist;
      best_attr <= attr2;
    end
  end

  // Result register and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v2 && last2;
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && last2) begin
      attribute_id <= result;
    end
  end

endmodule

`default_nettype wire

// ----- sv/nearest_palette_color_classifier.sv -----
// Top level of the nearest palette color classifier.
// Depends on npcc_pkg, npcc_front, npcc_queue, npcc_back and the macros header.
//
//   Channel  | Handshake              | Payload
//   ---------+------------------------+------------------------------------------
//   input    | start, busy            | op, red, green, blue, alpha, slot, entry_id
//   result   | done (one-cycle strobe)| attribute_id
//   config   | cfg_write              | cfg_index, cfg_data
//
// A transaction is taken when start is high and busy is low; busy means the
// two-entry command queue is full. The back end takes one command at a time: a
// load writes its palette slot as it leaves the queue, a full-mode pixel searches
// palette_size slots (size zero counts as one slot, sizes past 256 as 256) and a
// fast-mode pixel the forest colors, through the single distance unit that
// evaluates one palette slot from the palette memory read port or one forest
// color per cycle.
// Reset is synchronous and clears control state only; the palette is
// undefined until loaded. The receiver cannot stall results.
`default_nettype none
`include "nearest_palette_color_classifier_macros.svh"

module nearest_palette_color_classifier (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              op,
  input  wire logic [7:0]                        red,
  input  wire logic [7:0]                        green,
  input  wire logic [7:0]                        blue,
  input  wire logic [7:0]                        alpha,
  input  wire logic [7:0]                        slot,
  input  wire logic [7:0]                        entry_id,
  output logic                                   done,
  output logic [7:0]                             attribute_id,
  input  wire logic                              cfg_write,
  input  wire logic [npcc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [npcc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic                          push;
  npcc_pkg::cmd_t                push_cmd;
  logic                          pop;
  npcc_pkg::cmd_t                head;
  npcc_pkg::queue_status_t       q_status;
  logic [npcc_pkg::THR_W-1:0]    threshold;

  // Acceptance, decoding and configuration.
  npcc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .op        (op),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .alpha     (alpha),
    .slot      (slot),
    .entry_id  (entry_id),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_status  (q_status),
    .push      (push),
    .push_cmd  (push_cmd),
    .threshold (threshold)
  );

  // Command queue.
  npcc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  // Palette memory and search.
  npcc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_status     (q_status),
    .threshold    (threshold),
    .pop          (pop),
    .done         (done),
    .attribute_id (attribute_id)
  );

  assign busy = q_status.full;

  // Checks on queue and result sequencing.
  `NPCC_ASSERT_IMPLIES(a_queue_flags, clk, rst, q_status.full, !q_status.empty)
  `NPCC_ASSERT_IMPLIES(a_pop_nonempty, clk, rst, pop, !q_status.empty)
  `NPCC_ASSERT_NEXT(a_refused_keeps_queue, clk, rst, start && busy, !q_status.empty)
  `NPCC_ASSERT_NEXT(a_single_strobe, clk, rst, done, !done)

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking testbench for the nearest palette color classifier.
// Depends on npcc_pkg and the nearest_palette_color_classifier RTL; a scoreboard
// class predicts each attribute id while plain tasks drive pixels, loads and registers.
`default_nettype none

module tb_top;
  import npcc_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 500;
  localparam int SETTLE_CYCLES = 16;

  // Forest colors packed as A,B,G,R from the high byte down.
  localparam logic [31:0] FOREST_RGBA [3] = '{32'hFF63AA68, 32'hFF30631C, 32'hFF8EC9B5};

  // Predicts attribute ids and holds those still owed by the block.
  class attr_scoreboard;
    logic        mode_q;
    logic [8:0]  size_q;
    logic [17:0] thr_q;
    pixel_t      pal_color [256];
    logic [7:0]  pal_attr [256];
    logic [7:0]  expected_ids [$];
    int          errors;

    function void clear();
      mode_q = MODE_FAST;
      size_q = 9'd1;
      thr_q  = 18'd65;
      errors = 0;
      expected_ids.delete();
      for (int i = 0; i < 256; i++) begin
        pal_color[i] = '0;
        pal_attr[i]  = '0;
      end
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_MODE:      mode_q = val[0];
        CFG_SIZE:      size_q = val[8:0];
        CFG_THRESHOLD: thr_q  = val[17:0];
        default: ;
      endcase
    endfunction

    // Sum of squared byte differences over all four channels.
    function int unsigned rgba_dist(pixel_t a, pixel_t b);
      logic [31:0] av;
      logic [31:0] bv;
      int          d;
      int unsigned sum;
      av  = a;
      bv  = b;
      sum = 0;
      for (int i = 0; i < 4; i++) begin
        d   = int'(av[8*i +: 8]) - int'(bv[8*i +: 8]);
        sum = sum + d * d;
      end
      return sum;
    endfunction

    // Full search: strictly smaller distance wins, so the lowest slot keeps ties.
    function logic [7:0] nearest_attr(pixel_t px);
      int          count;
      int unsigned best_dist;
      int unsigned d;
      logic [7:0]  best;
      count     = (size_q > 9'd256) ? 256 : int'(size_q);
      best_dist = 32'hFFFFFFFF;
      best      = pal_attr[0];
      for (int s = 0; s < count; s++) begin
        d = rgba_dist(px, pal_color[s]);
        if (d < best_dist) begin
          best_dist = d;
          best      = pal_attr[s];
        end
      end
      return best;
    endfunction

    function logic [7:0] forest_attr(pixel_t px);
      for (int k = 0; k < 3; k++) begin
        if (rgba_dist(px, FOREST_RGBA[k]) <= int'(thr_q)) return FAST_HIT_ID;
      end
      return FAST_MISS_ID;
    endfunction

    // Called for each accepted input transaction.
    function void take_item(logic op_v, pixel_t px, logic [7:0] slot_v, logic [7:0] id_v);
      if (op_v == OP_LOAD) begin
        pal_color[slot_v] = px;
        pal_attr[slot_v]  = id_v;
      end else if (mode_q == MODE_FULL) begin
        expected_ids.push_back(nearest_attr(px));
      end else begin
        expected_ids.push_back(forest_attr(px));
      end
    endfunction

    // Called for each result strobe.
    function void check_id(logic [7:0] got);
      logic [7:0] want;
      if (expected_ids.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual attribute_id %0d",
                 $time, got);
        errors++;
      end else begin
        want = expected_ids.pop_front();
        if (got !== want) begin
          $display("%0t: attribute_id mismatch, expected %0d, actual %0d",
                   $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic                   op;
  logic [7:0]             red, green, blue, alpha, slot, entry_id;
  logic                   done;
  logic [7:0]             attribute_id;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  attr_scoreboard sb;
  int             cycles = 0;
  int             items_sent = 0;
  int             quiet_lo, quiet_hi;
  bit             written [256];

  nearest_palette_color_classifier dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .red(red), .green(green), .blue(blue), .alpha(alpha),
    .slot(slot), .entry_id(entry_id), .done(done), .attribute_id(attribute_id),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Every result strobe is checked at the edge that ends its cycle.
  always @(posedge clk) begin
    if (!rst && done) sb.check_id(attribute_id);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Offers one transaction and waits until the block takes it; start stays high after.
  task automatic send_item(input logic o, input pixel_t px, input logic [7:0] s,
                           input logic [7:0] e);
    bit quiet;
    quiet = (items_sent >= quiet_lo) && (items_sent < quiet_hi);
    @(negedge clk);
    if (!quiet && $urandom_range(99) < 6) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start    = 1'b1;
    op       = o;
    red      = px.red;
    green    = px.green;
    blue     = px.blue;
    alpha    = px.alpha;
    slot     = s;
    entry_id = e;
    do @(posedge clk); while (busy);
    sb.take_item(o, px, s, e);
    if (o == OP_LOAD) written[s] = 1'b1;
    items_sent++;
  endtask

  // Stops offering and waits until every pending id has come back and loads are done.
  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (sb.expected_ids.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_write = 1'b0;
    sb.set_reg(idx, val);
  endtask

  function automatic pixel_t rand_pixel();
    int r;
    r = $urandom_range(19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return pixel_t'($urandom);
  endfunction

  // Moves each channel of a base color by up to the spread, clamped to a byte.
  function automatic pixel_t near_pixel(input pixel_t base, input int spread);
    logic [31:0] bv;
    logic [31:0] pv;
    int          v;
    bv = base;
    for (int i = 0; i < 4; i++) begin
      v = int'(bv[8*i +: 8]) + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      pv[8*i +: 8] = v[7:0];
    end
    return pixel_t'(pv);
  endfunction

  // Fast mode burst: mostly pixels around the forest colors.
  task automatic fast_burst();
    int     r;
    pixel_t px;
    repeat ($urandom_range(10, 30)) begin
      r = $urandom_range(99);
      if (r < 10) begin
        send_item(OP_LOAD, rand_pixel(), 8'($urandom), 8'($urandom));
      end else begin
        if (r < 20) px = FOREST_RGBA[$urandom_range(2)];
        else if (r < 70) px = near_pixel(FOREST_RGBA[$urandom_range(2)], $urandom_range(1, 9));
        else px = rand_pixel();
        send_item(OP_CLASSIFY, px, 8'($urandom), 8'($urandom));
      end
    end
  endtask

  // Full mode burst: fill the searched slots first, then loads and pixels near them.
  task automatic full_burst();
    int     need;
    int     r;
    int     src;
    bit     big;
    pixel_t px;
    need = (sb.size_q == 0) ? 1 : ((sb.size_q > 9'd256) ? 256 : int'(sb.size_q));
    big  = need > 64;
    for (int s = 0; s < need; s++) begin
      if (!written[s]) send_item(OP_LOAD, rand_pixel(), 8'(s), 8'($urandom));
    end
    repeat (big ? $urandom_range(2, 5) : $urandom_range(8, 30)) begin
      r   = $urandom_range(99);
      src = $urandom_range(0, need - 1);
      if (r < 20) begin
        // Copying a color sets up ties between slots.
        px = ($urandom_range(1) == 1) ? sb.pal_color[src] : rand_pixel();
        send_item(OP_LOAD, px,
                  ($urandom_range(9) < 7) ? 8'($urandom_range(0, need - 1)) : 8'($urandom),
                  8'($urandom));
      end else begin
        if (r < 50) px = sb.pal_color[src];
        else if (r < 75) px = near_pixel(sb.pal_color[src], 8);
        else px = rand_pixel();
        send_item(OP_CLASSIFY, px, 8'($urandom), 8'($urandom));
      end
    end
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 70) return CFG_DATA_W'($urandom_range(1, 16));
    if (r < 85) return CFG_DATA_W'($urandom_range(17, 255));
    if (r < 90) return CFG_DATA_W'(256);
    if (r < 95) return CFG_DATA_W'($urandom_range(257, 511));
    return '0;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_threshold();
    int r;
    r = $urandom_range(99);
    if (r < 40) return CFG_DATA_W'(65);
    if (r < 60) return CFG_DATA_W'($urandom_range(0, 400));
    if (r < 70) return '0;
    if (r < 80) return CFG_DATA_W'($urandom_range(0, 20000));
    if (r < 90) return CFG_DATA_W'(260100);
    return '1;
  endfunction

  initial begin
    logic new_mode;
    int   dir_count;
    rst       = 1'b1;
    start     = 1'b0;
    op        = OP_CLASSIFY;
    red       = '0;
    green     = '0;
    blue      = '0;
    alpha     = '0;
    slot      = '0;
    entry_id  = '0;
    cfg_write = 1'b0;
    cfg_index = CFG_MODE;
    cfg_data  = '0;
    quiet_lo  = 0;
    quiet_hi  = 0;
    for (int i = 0; i < 256; i++) written[i] = 1'b0;
    sb = new;
    sb.clear();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Fast mode at reset settings: exact forest colors, threshold edge, extremes.
    send_item(OP_CLASSIFY, FOREST_RGBA[0], 8'd0, 8'd0);
    send_item(OP_CLASSIFY, FOREST_RGBA[1], 8'd0, 8'd0);
    send_item(OP_CLASSIFY, FOREST_RGBA[2], 8'd0, 8'd0);
    send_item(OP_CLASSIFY, 32'hFF306424, 8'd0, 8'd0);
    send_item(OP_CLASSIFY, 32'hFF316424, 8'd0, 8'd0);
    send_item(OP_CLASSIFY, 32'h00000000, 8'd0, 8'd0);
    send_item(OP_CLASSIFY, 32'hFFFFFFFF, 8'hFF, 8'hFF);
    send_item(OP_CLASSIFY, 32'h008EC9B5, 8'd0, 8'd0);

    // Zero threshold takes only an exact match; the all-ones threshold takes anything.
    drain_results();
    write_reg(CFG_THRESHOLD, '0);
    send_item(OP_CLASSIFY, FOREST_RGBA[2], 8'd0, 8'd0);
    send_item(OP_CLASSIFY, 32'hFF8EC9B6, 8'd0, 8'd0);
    drain_results();
    write_reg(CFG_THRESHOLD, '1);
    send_item(OP_CLASSIFY, 32'h00000000, 8'd0, 8'd0);

    // Full mode: size zero falls back to slot 0, equal colors go to the lower slot.
    drain_results();
    write_reg(CFG_MODE, CFG_DATA_W'(MODE_FULL));
    write_reg(CFG_SIZE, '0);
    send_item(OP_LOAD, 32'h40302010, 8'd0, 8'hAA);
    send_item(OP_LOAD, 32'h40302010, 8'd1, 8'h55);
    send_item(OP_LOAD, 32'hFFFFFFFF, 8'd2, 8'h33);
    send_item(OP_LOAD, 32'h00000000, 8'hFF, 8'hFF);
    send_item(OP_CLASSIFY, 32'hFFFFFFFF, 8'd0, 8'd0);
    drain_results();
    write_reg(CFG_SIZE, CFG_DATA_W'(3));
    send_item(OP_CLASSIFY, 32'h40302010, 8'd0, 8'd0);
    send_item(OP_CLASSIFY, 32'hFFFFFFFF, 8'd0, 8'd0);
    send_item(OP_CLASSIFY, 32'h41302010, 8'd0, 8'd0);

    // Random phases, each under its own register setting, with one stretch free of gaps.
    dir_count = items_sent;
    quiet_lo  = dir_count + 150;
    quiet_hi  = dir_count + 300;
    while (items_sent < dir_count + RANDOM_ITEMS) begin
      drain_results();
      new_mode = 1'($urandom_range(1));
      if (new_mode != sb.mode_q || $urandom_range(1) == 1)
        write_reg(CFG_MODE, CFG_DATA_W'(new_mode));
      if (new_mode == MODE_FULL) begin
        write_reg(CFG_SIZE, pick_size());
        if ($urandom_range(3) == 0) write_reg(CFG_THRESHOLD, pick_threshold());
        full_burst();
      end else begin
        write_reg(CFG_THRESHOLD, pick_threshold());
        if ($urandom_range(3) == 0) write_reg(CFG_SIZE, pick_size());
        fast_burst();
      end
    end

    drain_results();
    if (sb.errors == 0 && sb.expected_ids.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+sv
sv/npcc_pkg.sv
sv/npcc_front.sv
sv/npcc_queue.sv
sv/npcc_back.sv
sv/nearest_palette_color_classifier.sv
bench/tb_top.sv
